// ===== sv/rgbled_pkg.sv =====
package rgbled_pkg;

    // Item kinds carried in the action field
    typedef enum logic [1:0] {
        ACT_SET_ONE = 2'd0,
        ACT_SET_ALL = 2'd1,
        ACT_POLL    = 2'd2,
        ACT_TICK    = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  led_index;
        logic [23:0] colour_rgb;
        logic        force_refresh;
    } item_t;

    typedef struct packed {
        logic [23:0] scaled_rgb;
        logic [2:0]  pixel_index;
        logic        last_pixel;
    } pixel_t;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFRESH_GAP = 1'd1;

    localparam logic [7:0]  BRIGHT_RESET = 8'd10;
    localparam logic [15:0] GAP_RESET    = 16'd1000;
    localparam logic [7:0]  BRIGHT_MAX   = 8'd100;

    localparam int COLOUR_W  = 24;
    localparam int CHAN_W    = 8;
    localparam int BRIGHT_W  = 7;
    localparam int ELAPSED_W = 17;

    // floor(p / 100) for p < 2^15 as (p * 41944) >> 22, exact over that range
    localparam int PROD_W       = CHAN_W + BRIGHT_W;
    localparam int RECIP_W      = 16;
    localparam int QUOT_W       = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV100_RECIP = 16'd41944;
    localparam int DIV100_SHIFT = 22;

    // Channel select codes within one pixel
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_RD,
        ST_SET_WR,
        ST_PIX_RD,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } seq_state_t;

    // Request to the shared channel scaler
    typedef struct packed {
        logic                load;
        logic [CHAN_W-1:0]   chan;
        logic [BRIGHT_W-1:0] bright;
    } scl_req_t;

endpackage

// ===== sv/rgbled_store.sv =====
module rgbled_store #(
    parameter int NUM_LEDS = 6,
    parameter int IDX_W    = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [IDX_W-1:0]              rd_addr,
    input  logic                          wr_en,
    input  logic [IDX_W-1:0]              wr_addr,
    input  logic [rgbled_pkg::COLOUR_W-1:0] wr_data,
    output logic [rgbled_pkg::COLOUR_W-1:0] rd_entry
);
    import rgbled_pkg::*;

    logic [COLOUR_W-1:0] mem [NUM_LEDS];
    logic [NUM_LEDS-1:0] valid_reg;
    logic [COLOUR_W-1:0] rd_data_reg;
    logic                rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Entries never written read as black
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== sv/rgbled_scaler.sv =====
module rgbled_scaler (
    input  logic                            clk,
    input  rgbled_pkg::scl_req_t            req,
    output logic [rgbled_pkg::CHAN_W-1:0]   scaled
);
    import rgbled_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic              nonzero_reg;
    logic [QUOT_W-1:0] quot_full;
    logic [CHAN_W-1:0] quot;

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            prod_reg    <= PROD_W'(req.chan) * PROD_W'(req.bright);
            nonzero_reg <= (req.chan != '0);
        end
    end

    // Divide by 100 through the reciprocal; keep a lit channel lit
    assign quot_full = QUOT_W'(prod_reg) * QUOT_W'(DIV100_RECIP);
    assign quot      = quot_full[DIV100_SHIFT +: CHAN_W];
    assign scaled    = (nonzero_reg && quot == '0) ? CHAN_W'(1) : quot;

endmodule

// ===== sv/rgbled_seq.sv =====
module rgbled_seq #(
    parameter int NUM_LEDS = 6,
    parameter int IDX_W    = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rgbled_pkg::item_t                 item,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [7:0]                        brightness,
    input  logic [15:0]                       refresh_gap,
    output logic [IDX_W-1:0]                  mem_addr,
    output logic                              mem_wr_en,
    output logic [rgbled_pkg::COLOUR_W-1:0]   mem_wr_data,
    input  logic [rgbled_pkg::COLOUR_W-1:0]   mem_entry,
    output rgbled_pkg::scl_req_t              scl_req,
    input  logic [rgbled_pkg::CHAN_W-1:0]     scl_result,
    input  logic                              out_free,
    output logic                              emit,
    output rgbled_pkg::pixel_t                emit_pixel
);
    import rgbled_pkg::*;

    seq_state_t            state_reg, state_next;
    logic [IDX_W-1:0]      addr_reg, addr_next;
    logic                  all_reg, all_next;
    logic [COLOUR_W-1:0]   colour_reg, colour_next;
    logic                  dirty_reg, dirty_next;
    logic [7:0]            applied_reg, applied_next;
    logic [BRIGHT_W-1:0]   bright_reg, bright_next;
    logic [ELAPSED_W-1:0]  elapsed_reg, elapsed_next;
    logic [1:0]            chan_reg, chan_next;
    logic [COLOUR_W-1:0]   pix_reg, pix_next;

    logic accept;
    logic in_range;
    logic last_led;
    logic differs;
    logic dirty_now;
    logic want_refresh;
    logic gap_passed;

    assign accept     = item_valid && !item_stall;
    assign in_range   = (32'(item.led_index) < NUM_LEDS);
    assign last_led   = (addr_reg == IDX_W'(NUM_LEDS - 1));
    assign differs    = (mem_entry != colour_reg);
    assign dirty_now  = dirty_reg || (brightness != applied_reg);
    assign want_refresh = dirty_now || item.force_refresh;
    assign gap_passed = (elapsed_reg > ELAPSED_W'(refresh_gap));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (action_t'(item.action))
                        ACT_SET_ONE: if (in_range) state_next = ST_SET_RD;
                        ACT_SET_ALL: state_next = ST_SET_RD;
                        ACT_POLL:    if (want_refresh && gap_passed) state_next = ST_PIX_RD;
                        ACT_TICK:    state_next = ST_IDLE;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SET_RD: state_next = ST_SET_WR;
            ST_SET_WR: state_next = (all_reg && !last_led) ? ST_SET_RD : ST_IDLE;
            ST_PIX_RD: state_next = ST_MUL;
            ST_MUL:    state_next = ST_DIV;
            ST_DIV:    state_next = (chan_reg == CH_BLUE) ? ST_EMIT : ST_MUL;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last_led ? ST_IDLE : ST_PIX_RD;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_stall  = (state_reg != ST_IDLE);
        mem_addr    = addr_reg;
        mem_wr_en   = (state_reg == ST_SET_WR) && differs;
        mem_wr_data = colour_reg;
        scl_req.load   = (state_reg == ST_MUL);
        scl_req.bright = bright_reg;
        case (chan_reg)
            CH_RED:   scl_req.chan = mem_entry[23:16];
            CH_GREEN: scl_req.chan = mem_entry[15:8];
            default:  scl_req.chan = mem_entry[7:0];
        endcase
        emit = (state_reg == ST_EMIT) && out_free;
        emit_pixel.scaled_rgb  = pix_reg;
        emit_pixel.pixel_index = 3'(addr_reg);
        emit_pixel.last_pixel  = last_led;
    end

    always_comb
    begin
        addr_next    = addr_reg;
        all_next     = all_reg;
        colour_next  = colour_reg;
        dirty_next   = dirty_reg;
        applied_next = applied_reg;
        bright_next  = bright_reg;
        elapsed_next = elapsed_reg;
        chan_next    = chan_reg;
        pix_next     = pix_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action_t'(item.action))
                        ACT_SET_ONE:
                        begin
                            addr_next   = IDX_W'(item.led_index);
                            all_next    = 1'b0;
                            colour_next = item.colour_rgb;
                        end
                        ACT_SET_ALL:
                        begin
                            addr_next   = '0;
                            all_next    = 1'b1;
                            colour_next = item.colour_rgb;
                        end
                        ACT_TICK:
                        begin
                            if (!gap_passed)
                            begin
                                elapsed_next = elapsed_reg + ELAPSED_W'(1);
                            end
                        end
                        default:
                        begin
                            // Poll: pick up a new brightness, then refresh or defer
                            applied_next = brightness;
                            bright_next  = (brightness > BRIGHT_MAX) ?
                                           BRIGHT_W'(BRIGHT_MAX) : BRIGHT_W'(brightness);
                            dirty_next   = dirty_now;
                            if (want_refresh)
                            begin
                                if (gap_passed)
                                begin
                                    dirty_next   = 1'b0;
                                    elapsed_next = '0;
                                    addr_next    = '0;
                                end
                                else
                                begin
                                    dirty_next = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_SET_WR:
            begin
                if (differs)
                begin
                    dirty_next = 1'b1;
                end
                if (all_reg && !last_led)
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            ST_PIX_RD:
            begin
                chan_next = CH_RED;
            end
            ST_DIV:
            begin
                case (chan_reg)
                    CH_RED:   pix_next[23:16] = scl_result;
                    CH_GREEN: pix_next[15:8]  = scl_result;
                    default:  pix_next[7:0]   = scl_result;
                endcase
                chan_next = chan_reg + 2'd1;
            end
            ST_EMIT:
            begin
                if (out_free && !last_led)
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            default:
            begin
                addr_next = addr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            addr_reg    <= '0;
            all_reg     <= 1'b0;
            dirty_reg   <= 1'b1;
            applied_reg <= BRIGHT_RESET;
            bright_reg  <= BRIGHT_W'(BRIGHT_RESET);
            elapsed_reg <= '0;
            chan_reg    <= CH_RED;
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            all_reg     <= all_next;
            dirty_reg   <= dirty_next;
            applied_reg <= applied_next;
            bright_reg  <= bright_next;
            elapsed_reg <= elapsed_next;
            chan_reg    <= chan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        colour_reg <= colour_next;
        pix_reg    <= pix_next;
    end

endmodule

// ===== sv/rgb_led_refresh_with_brightness.sv =====
// A set-one item in range reads one store entry and writes it if the colour differs; a set-all
// item does so for every LED; tick, and poll without refresh, leave the sequencer idle.
// A refresh poll walks every pixel, held by output stall; each pixel is one store read,
// three channels through the shared multiply/divide-by-100 scaler and one emit.
// The first pixel beat is registered after that pixel's read, scale and emit states; input stalls while busy.
// Reset (async, active low) clears the sequencer, marks the frame dirty, restores
// brightness 10 and gap 1000, and clears the store's valid bits so all LEDs read black.
module rgb_led_refresh_with_brightness #(
    parameter int NUM_LEDS = 6
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rgbled_pkg::item_t                     item,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    output rgbled_pkg::pixel_t                    pixel,
    output logic                                  pixel_valid,
    input  logic                                  pixel_stall,
    input  logic                                  cfg_we,
    input  logic [rgbled_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rgbled_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rgbled_pkg::*;

    // Address width of the colour store; one bit minimum for a single LED
    localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

    // Configuration registers
    logic [7:0]  brightness_reg;
    logic [15:0] gap_reg;

    // Output beat register: parts the sequencer from the downstream stall
    logic   pix_valid_reg;
    pixel_t pix_data_reg;

    logic [IDX_W-1:0]    mem_addr;
    logic                mem_wr_en;
    logic [COLOUR_W-1:0] mem_wr_data;
    logic [COLOUR_W-1:0] mem_entry;
    scl_req_t            scl_req;
    logic [CHAN_W-1:0]   scl_result;
    logic                out_free;
    logic                emit;
    pixel_t              emit_pixel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= BRIGHT_RESET;
            gap_reg        <= GAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BRIGHTNESS:  brightness_reg <= cfg_data[7:0];
                REG_REFRESH_GAP: gap_reg        <= cfg_data;
                default:         gap_reg        <= gap_reg;
            endcase
        end
    end

    // The output slot is free when empty or when its beat leaves this cycle
    assign out_free = !pix_valid_reg || !pixel_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            pix_valid_reg <= 1'b1;
        end
        else if (!pixel_stall)
        begin
            pix_valid_reg <= 1'b0;
        end
    end

    // Load a new beat only when the slot is free; hold it under stall
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pix_data_reg <= emit_pixel;
        end
    end

    assign pixel_valid = pix_valid_reg;
    assign pixel       = pix_data_reg;

    // Colour store: one read, one write port, registered read
    rgbled_store #(
        .NUM_LEDS (NUM_LEDS),
        .IDX_W    (IDX_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (mem_addr),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_addr),
        .wr_data  (mem_wr_data),
        .rd_entry (mem_entry)
    );

    // Shared scaler: multiply by brightness, then divide by 100
    rgbled_scaler u_scaler (
        .clk    (clk),
        .req    (scl_req),
        .scaled (scl_result)
    );

    // Sequencer: item decode, dirty/elapsed tracking, refresh walk
    rgbled_seq #(
        .NUM_LEDS (NUM_LEDS),
        .IDX_W    (IDX_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .brightness  (brightness_reg),
        .refresh_gap (gap_reg),
        .mem_addr    (mem_addr),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_data (mem_wr_data),
        .mem_entry   (mem_entry),
        .scl_req     (scl_req),
        .scl_result  (scl_result),
        .out_free    (out_free),
        .emit        (emit),
        .emit_pixel  (emit_pixel)
    );

endmodule

// ===== tb/pixel_checker.sv =====
`timescale 1ns / 100ps

module pixel_checker #(
    parameter int NUM_LEDS = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rgbled_pkg::item_t                 item,
    input  logic                              item_valid,
    input  logic                              item_stall,
    input  rgbled_pkg::pixel_t                pixel,
    input  logic                              pixel_valid,
    input  logic                              pixel_stall,
    input  logic                              cfg_we,
    input  logic [rgbled_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgbled_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                errors,
    output int                                pending
);
    import rgbled_pkg::*;

    // shadow of the block's registers and frame state
    logic [7:0]     bright_reg;
    logic [15:0]    gap_reg;
    logic [23:0]    colours [NUM_LEDS];
    logic           dirty;
    logic [7:0]     applied;
    logic [16:0]    elapsed;

    pixel_t         want_q [$];
    int             n_err;

    function automatic logic [23:0] dimmed(input logic [23:0] c);
        int b;
        int ch;
        int s;
        logic [23:0] r;
        b = (applied > BRIGHT_MAX) ? int'(BRIGHT_MAX) : int'(applied);
        for (int k = 0; k < 3; k++)
        begin
            ch = int'(c[8*k +: 8]);
            s  = (ch * b) / int'(BRIGHT_MAX);
            // a lit channel never goes dark
            if (ch != 0 && s == 0)
                s = 1;
            r[8*k +: 8] = s[7:0];
        end
        return r;
    endfunction

    task automatic store_colour(input int idx, input logic [23:0] c);
        if (idx < NUM_LEDS)
        begin
            if (colours[idx] != c)
            begin
                colours[idx] = c;
                dirty = 1'b1;
            end
        end
    endtask

    task automatic predict_frame(input item_t it);
        pixel_t px;
        case (action_t'(it.action))
            ACT_SET_ONE: store_colour(int'(it.led_index), it.colour_rgb);
            ACT_SET_ALL:
                for (int i = 0; i < NUM_LEDS; i++)
                    store_colour(i, it.colour_rgb);
            ACT_TICK:
                if (elapsed <= {1'b0, gap_reg})
                    elapsed = elapsed + 17'd1;
            default:
            begin
                if (bright_reg != applied)
                begin
                    dirty = 1'b1;
                    applied = bright_reg;
                end
                if (dirty || it.force_refresh)
                begin
                    if (elapsed > {1'b0, gap_reg})
                    begin
                        for (int i = 0; i < NUM_LEDS; i++)
                        begin
                            px.scaled_rgb  = dimmed(colours[i]);
                            px.pixel_index = 3'(i);
                            px.last_pixel  = (i == NUM_LEDS - 1);
                            want_q.push_back(px);
                        end
                        elapsed = '0;
                        dirty = 1'b0;
                    end
                    else
                    begin
                        dirty = 1'b1;
                    end
                end
            end
        endcase
    endtask

    task automatic check_pixel(input pixel_t got);
        pixel_t want;
        if (want_q.size() == 0)
        begin
            n_err++;
            if (n_err <= 10)
                $display("unexpected pixel: rgb %h index %0d last %0b",
                         got.scaled_rgb, got.pixel_index, got.last_pixel);
        end
        else
        begin
            want = want_q.pop_front();
            if (got.scaled_rgb !== want.scaled_rgb || got.pixel_index !== want.pixel_index ||
                got.last_pixel !== want.last_pixel)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("pixel mismatch: rgb %h/%h index %0d/%0d last %0b/%0b (exp/got)",
                             want.scaled_rgb, got.scaled_rgb, want.pixel_index,
                             got.pixel_index, want.last_pixel, got.last_pixel);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg = BRIGHT_RESET;
            gap_reg    = GAP_RESET;
            for (int i = 0; i < NUM_LEDS; i++)
                colours[i] = '0;
            dirty   = 1'b1;
            applied = BRIGHT_RESET;
            elapsed = '0;
            want_q.delete();
            n_err = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // check before predicting: a beat leaving now is never caused by an item entering now
            if (pixel_valid && !pixel_stall)
                check_pixel(pixel);
            if (cfg_we)
            begin
                if (cfg_index == REG_BRIGHTNESS)
                    bright_reg = cfg_data[7:0];
                else if (cfg_index == REG_REFRESH_GAP)
                    gap_reg = cfg_data[15:0];
            end
            if (item_valid && !item_stall)
                predict_frame(item);
            errors  <= n_err;
            pending <= want_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import rgbled_pkg::*;

    localparam int NUM_LEDS      = 6;
    localparam int IDLE_PCT      = 19;
    // a set-all keeps the block busy with nothing to show for it
    localparam int SETTLE_CYCLES = 2 * NUM_LEDS + 12;
    localparam int CYCLE_LIMIT   = 400000;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    item_t                 item        = '0;
    logic                  item_valid  = 1'b0;
    logic                  item_stall;
    pixel_t                pixel;
    logic                  pixel_valid;
    logic                  pixel_stall = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    int  errors;
    int  pending;
    int  cycles = 0;
    // when set, neither side idles
    bit  calm = 1'b0;

    always #5 clk = ~clk;

    rgb_led_refresh_with_brightness #(
        .NUM_LEDS    (NUM_LEDS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .pixel       (pixel),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    pixel_checker #(
        .NUM_LEDS    (NUM_LEDS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .pixel       (pixel),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending)
    );

    // Stall the pixel side at random, except during the calm stretch.
    always @(posedge clk)
        pixel_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Present one beat and hold it until the block takes it. Valid stays high on return,
    // so a following beat can go out back to back.
    task automatic send(input action_t act, input logic [2:0] idx, input logic [23:0] colour,
                        input logic force_it);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item.action        <= act;
        item.led_index     <= idx;
        item.colour_rgb    <= colour;
        item.force_refresh <= force_it;
        item_valid         <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // Drop valid, wait for every predicted pixel, then let a silent item finish.
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; only call while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Brightness lives in the low byte; junk the upper byte to show it is ignored.
    task automatic write_brightness(input logic [7:0] pct);
        write_reg(REG_BRIGHTNESS, {8'($urandom_range(0, 255)), pct});
    endtask

    // Favor black, full and near-black channels so clamp and round-up cases come up often.
    function automatic logic [23:0] rand_colour();
        logic [23:0] c;
        for (int k = 0; k < 3; k++)
        begin
            case ($urandom_range(0, 4))
                0:       c[8*k +: 8] = 8'h00;
                1:       c[8*k +: 8] = 8'hFF;
                2:       c[8*k +: 8] = 8'($urandom_range(1, 3));
                default: c[8*k +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return c;
    endfunction

    // Random traffic: mostly ticks and polls so refreshes keep happening, with set items
    // mixed in (out-of-range LEDs included) and all unused fields randomized.
    task automatic random_run(input int n_items);
        int      r;
        action_t act;
        for (int n = 0; n < n_items; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                act = ACT_SET_ONE;
            else if (r < 25)
                act = ACT_SET_ALL;
            else if (r < 65)
                act = ACT_TICK;
            else
                act = ACT_POLL;
            send(act, 3'($urandom_range(0, 7)), rand_colour(), 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: gap of 1000 means nothing can refresh yet. A plain poll on the
        // dirty reset frame and a forced one both come too early.
        send(ACT_POLL, 3'd0, 24'h000000, 1'b0);
        send(ACT_TICK, 3'd7, 24'hFFFFFF, 1'b1);
        send(ACT_POLL, 3'd0, 24'h000000, 1'b1);
        settle();

        // Zero gap, zero brightness: every lit channel must round up to 1.
        write_reg(REG_REFRESH_GAP, 16'd0);
        write_brightness(8'd0);
        send(ACT_SET_ONE, 3'd0, 24'hFFFFFF, 1'b1);
        send(ACT_SET_ONE, 3'd5, 24'h800001, 1'b0);
        send(ACT_SET_ONE, 3'd6, 24'h123456, 1'b0);   // beyond the last LED: ignored
        send(ACT_SET_ONE, 3'd7, 24'hABCDEF, 1'b0);
        send(ACT_POLL, 3'd0, 24'h000000, 1'b0);      // one tick banked above zero gap
        send(ACT_TICK, 3'd0, 24'h000000, 1'b0);
        send(ACT_POLL, 3'd3, 24'h555555, 1'b0);      // clean frame, no force: silent
        send(ACT_TICK, 3'd0, 24'h000000, 1'b0);
        send(ACT_POLL, 3'd0, 24'h000000, 1'b1);      // forced refresh of a clean frame
        send(ACT_SET_ONE, 3'd0, 24'hFFFFFF, 1'b0);   // same colour: stays clean
        send(ACT_TICK, 3'd0, 24'h000000, 1'b0);
        send(ACT_POLL, 3'd0, 24'h000000, 1'b0);
        settle();

        // Brightness above full scale clamps; ticks saturate at gap + 1.
        write_brightness(8'd255);
        write_reg(REG_REFRESH_GAP, 16'd2);
        send(ACT_SET_ALL, 3'd2, 24'hFF8001, 1'b1);
        repeat (5) send(ACT_TICK, 3'd0, 24'h000000, 1'b0);
        send(ACT_POLL, 3'd0, 24'h000000, 1'b0);
        send(ACT_TICK, 3'd0, 24'h000000, 1'b0);
        send(ACT_POLL, 3'd0, 24'h000000, 1'b1);      // too early: leaves the frame dirty
        send(ACT_TICK, 3'd0, 24'h000000, 1'b0);
        send(ACT_TICK, 3'd0, 24'h000000, 1'b0);
        send(ACT_POLL, 3'd0, 24'h000000, 1'b0);
        settle();

        // Widest gap: a brightness change dirties the frame but nothing can go out.
        write_brightness(8'd100);
        write_reg(REG_REFRESH_GAP, 16'hFFFF);
        send(ACT_TICK, 3'd0, 24'h000000, 1'b0);
        send(ACT_POLL, 3'd0, 24'h000000, 1'b1);
        settle();

        // Random phases, each with fresh settings; the third one runs without idling.
        for (int p = 0; p < 5; p++)
        begin
            case ($urandom_range(0, 4))
                0:       write_brightness(8'd0);
                1:       write_brightness(8'd255);
                2:       write_brightness(8'd101);
                default: write_brightness(8'($urandom_range(0, 255)));
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_REFRESH_GAP, 16'($urandom_range(0, 12)));
            else
                write_reg(REG_REFRESH_GAP, 16'($urandom_range(0, 3)));
            calm = (p == 2);
            random_run(24);
            settle();
        end
        calm = 1'b0;

        repeat (60) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
sv/rgbled_pkg.sv
sv/rgbled_store.sv
sv/rgbled_scaler.sv
sv/rgbled_seq.sv
sv/rgb_led_refresh_with_brightness.sv
tb/pixel_checker.sv
tb/tb.sv
